// ===== sv/stq_pkg.sv =====
// Shared types and constants for the sorted timer queue.
package stq_pkg;

    localparam logic [1:0] CMD_SCHED  = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [2:0] KIND_SCHED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_NOT_SCHED = 3'd3;
    localparam logic [2:0] KIND_FIRED     = 3'd4;
    localparam logic [2:0] KIND_NONE      = 3'd5;

    localparam logic [19:0] TS_RESET = 20'd16667;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [31:0]        now_tick;
        logic signed [31:0] duration_us;
        logic               is_wait;
        logic [15:0]        thread_id;
        logic [7:0]         arg_count;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] fired_thread;
        logic        fired_wait;
        logic [7:0]  fired_args;
        logic [51:0] elapsed_us;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [32:0] deadline;
        logic [15:0] thread;
        logic        is_wait;
        logic [7:0]  args;
        logic [31:0] start_tick;
    } t_entry;

    typedef struct packed {
        logic       do_ins;
        logic       do_cancel;
        logic       do_pop;
        t_entry     new_ent;
        logic [15:0] thr;
    } t_cell_ctl;

endpackage

// ===== sv/stq_div.sv =====
// Restoring divider, one quotient bit per cycle.
module stq_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [19:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [19:0] r_rem;
    logic [31:0] r_q;
    logic [19:0] r_dvs;
    logic [20:0] w_sh;
    logic        w_ge;
    logic [20:0] w_sub;

    assign w_sh  = {r_rem, r_q[31]};
    assign w_ge  = w_sh >= {1'b0, r_dvs};
    assign w_sub = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[19:0] : w_sh[19:0];
            r_q   <= {r_q[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== sv/stq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts it left or right.
module stq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stq_pkg::t_cell_ctl i_ctl,
    input  logic               i_left_keep,
    input  logic               i_left_valid,
    input  stq_pkg::t_entry    i_left_ent,
    input  logic               i_right_valid,
    input  stq_pkg::t_entry    i_right_ent,
    input  logic               i_pref,
    output logic               o_keep,
    output logic               o_pref,
    output logic               o_valid,
    output stq_pkg::t_entry    o_ent
);
    import stq_pkg::*;

    logic   r_valid;
    t_entry r_ent;
    logic   n_valid;
    t_entry n_ent;
    logic   w_match;

    assign o_keep  = r_valid && (r_ent.deadline <= i_ctl.new_ent.deadline);
    assign w_match = r_valid && (r_ent.thread == i_ctl.thr);
    assign o_pref  = i_pref | w_match;

    always_comb begin
        n_valid = r_valid;
        n_ent   = r_ent;
        if (i_ctl.do_ins) begin
            if (!o_keep) begin
                if (i_left_keep) begin
                    n_valid = 1'b1;
                    n_ent   = i_ctl.new_ent;
                end else begin
                    n_valid = i_left_valid;
                    n_ent   = i_left_ent;
                end
            end
        end else if ((i_ctl.do_cancel && o_pref) || i_ctl.do_pop) begin
            n_valid = i_right_valid;
            n_ent   = i_right_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_valid = r_valid;
    assign o_ent   = r_ent;
endmodule

// ===== sv/sorted_timer_queue_top.sv =====
// Sorted timer queue: a chain of entry cells, a serial divider and a result register.
// A schedule beat runs through the serial divider before the insert and its result;
// with a zero timestep, a non-positive duration or a full queue the divider is skipped.
// Cancel gives one result beat; a tick gives one per due entry, or a KIND_NONE beat.
// One command is in work at a time; the divider sets the rate of schedule beats.
// Synchronous reset empties the queue and loads the timestep with 16667; no clearing pass.
module sorted_timer_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [19:0]   i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  stq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output stq_pkg::t_out o_out_data
);
    import stq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_INS  = 6'b000100,
        S_CAN  = 6'b001000,
        S_TICK = 6'b010000,
        S_FULL = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    t_in         r_in;
    logic [32:0] r_dl;
    logic [19:0] r_ts;
    t_out        r_out, n_out;
    logic        r_ov, n_ov;

    t_cell_ctl   w_ctl;
    t_entry      w_ent   [DEPTH];
    logic        w_valid [DEPTH];
    logic        w_keep  [DEPTH];
    logic        w_pref  [DEPTH];

    logic        w_slot;
    logic        w_acc;
    logic        w_full;
    logic        w_due0, w_due1;
    logic        w_fast;
    logic        w_div_start, w_div_done;
    logic [31:0] w_dividend, w_quot;
    logic [31:0] w_diff;
    logic [51:0] w_prod;

    assign w_slot = !r_ov || !i_out_stall;
    assign w_acc  = i_in_valid && (r_state == S_IDLE);
    assign w_full = w_valid[DEPTH-1];
    assign w_due0 = w_valid[0] && (w_ent[0].deadline <= {1'b0, r_in.now_tick});
    assign w_due1 = w_valid[1] && (w_ent[1].deadline <= {1'b0, r_in.now_tick});
    assign w_fast = (r_ts == 20'd0) || i_in_data.duration_us[31]
                    || (i_in_data.duration_us == 32'sd0);
    assign w_dividend = {1'b0, i_in_data.duration_us[30:0]} + {12'd0, r_ts} - 32'd1;
    assign w_div_start = w_acc && (i_in_data.cmd == CMD_SCHED) && !w_full && !w_fast;
    assign w_diff = r_in.now_tick - w_ent[0].start_tick;
    assign w_prod = w_diff * r_ts;

    stq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_ts),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_ctl.do_ins    = (r_state == S_INS) && w_slot;
        w_ctl.do_cancel = (r_state == S_CAN) && w_slot;
        w_ctl.do_pop    = (r_state == S_TICK) && w_slot && w_due0;
        w_ctl.new_ent   = {r_dl, r_in.thread_id, r_in.is_wait, r_in.arg_count, r_in.now_tick};
        w_ctl.thr       = r_in.thread_id;
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic   w_lk, w_lv, w_rv, w_pi;
        t_entry w_le, w_re;
        if (gi == 0) begin : g_first
            assign w_lk = 1'b1;
            assign w_lv = 1'b0;
            assign w_le = '0;
            assign w_pi = 1'b0;
        end else begin : g_mid
            assign w_lk = w_keep[gi-1];
            assign w_lv = w_valid[gi-1];
            assign w_le = w_ent[gi-1];
            assign w_pi = w_pref[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_rv = 1'b0;
            assign w_re = '0;
        end else begin : g_inner
            assign w_rv = w_valid[gi+1];
            assign w_re = w_ent[gi+1];
        end
        stq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_left_keep   (w_lk),
            .i_left_valid  (w_lv),
            .i_left_ent    (w_le),
            .i_right_valid (w_rv),
            .i_right_ent   (w_re),
            .i_pref        (w_pi),
            .o_keep        (w_keep[gi]),
            .o_pref        (w_pref[gi]),
            .o_valid       (w_valid[gi]),
            .o_ent         (w_ent[gi])
        );
    end

    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        n_ov    = r_ov && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_in_data.cmd)
                        CMD_SCHED: begin
                            if (w_full) begin
                                n_state = S_FULL;
                            end else if (w_fast) begin
                                n_state = S_INS;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                        CMD_CANCEL: n_state = S_CAN;
                        CMD_TICK:   n_state = S_TICK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_INS;
                end
            end
            S_INS, S_FULL: begin
                if (w_slot) begin
                    n_out      = '0;
                    n_out.kind = (r_state == S_FULL) ? KIND_FULL : KIND_SCHED;
                    n_out.last = 1'b1;
                    n_ov       = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_CAN: begin
                if (w_slot) begin
                    n_out              = '0;
                    n_out.kind         = w_pref[DEPTH-1] ? KIND_CANCELLED : KIND_NOT_SCHED;
                    n_out.fired_thread = r_in.thread_id;
                    n_out.last         = 1'b1;
                    n_ov               = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_TICK: begin
                if (w_slot) begin
                    n_out = '0;
                    n_ov  = 1'b1;
                    if (w_due0) begin
                        n_out.kind         = KIND_FIRED;
                        n_out.fired_thread = w_ent[0].thread;
                        n_out.fired_wait   = w_ent[0].is_wait;
                        n_out.fired_args   = w_ent[0].is_wait ? 8'd0 : w_ent[0].args;
                        n_out.elapsed_us   = w_ent[0].is_wait ? w_prod : 52'd0;
                        n_out.last         = !w_due1;
                        if (!w_due1) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_out.kind = KIND_NONE;
                        n_out.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_ts    <= TS_RESET;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_ts <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_acc) begin
            r_in <= i_in_data;
            r_dl <= {1'b0, i_in_data.now_tick} + 33'd1;
        end else if (r_state == S_DIV && w_div_done) begin
            r_dl <= {1'b0, r_in.now_tick} + {1'b0, w_quot};
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
endmodule
